/* sv/cbam_pkg.sv */
// Shared types, codes and constants of the cartridge bus address mapper.
package cbam_pkg;

    localparam int DVD_W = 24;  // linear address before mirroring
    localparam int REM_W = 25;  // store sizes and the running remainder
    localparam int BITS_PER_STAGE = 2;

    localparam logic [7:0] LO_SRAM_BANK_FIRST = 8'h70;
    localparam logic [7:0] LO_SRAM_BANK_END   = 8'h7E;
    localparam logic [7:0] HI_SRAM_BANK_FIRST = 8'h30;
    localparam logic [7:0] HI_SRAM_BANK_END   = 8'h40;
    localparam logic [15:0] HI_SRAM_OFF_FIRST = 16'h6000;
    localparam logic [15:0] HI_SRAM_OFF_END   = 16'h8000;
    localparam logic [6:0] CP_ROM_LO_BANK_END  = 7'h40;
    localparam logic [6:0] CP_ROM_HI_BANK_END  = 7'h60;
    localparam logic [7:0] CP_EXTRAM_BANK0 = 8'h70;
    localparam logic [7:0] CP_EXTRAM_BANK1 = 8'h71;
    localparam logic [7:0] CP_SRAM_BANK0   = 8'h78;
    localparam logic [7:0] CP_SRAM_BANK1   = 8'h79;
    // Larger than any in-bank offset, so the remainder leaves it unchanged.
    localparam logic [REM_W-1:0] PASS_DIVISOR = REM_W'(1) << 24;

    localparam logic [1:0]       RST_MAP_MODE    = 2'd0;
    localparam logic [REM_W-1:0] RST_ROM_SIZE    = 25'd1048576;
    localparam logic [19:0]      RST_SRAM_SIZE   = 20'd0;
    localparam logic [17:0]      RST_EXTRAM_SIZE = 18'd131072;

    typedef enum logic [2:0] {
        TGT_NONE   = 3'd0,
        TGT_ROM    = 3'd1,
        TGT_SRAM   = 3'd2,
        TGT_EXTRAM = 3'd3,
        TGT_COPIO  = 3'd4
    } t_target;

    typedef enum logic [1:0] {
        MAP_LO    = 2'd0,
        MAP_HI    = 2'd1,
        MAP_COPRO = 2'd2
    } t_map_mode;

    typedef enum logic [1:0] {
        CFG_MAP_MODE    = 2'd0,
        CFG_ROM_SIZE    = 2'd1,
        CFG_SRAM_SIZE   = 2'd2,
        CFG_EXTRAM_SIZE = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [1:0]       map_mode;
        logic [REM_W-1:0] rom_size;
        logic [19:0]      sram_size;
        logic [17:0]      extram_size;
    } t_cfg;

    // Fields that ride along the remainder pipeline untouched.
    typedef struct packed {
        t_target    target;
        logic       write_enable;
        logic [7:0] data;
        logic       dirty;
    } t_side;

endpackage

/* sv/cbam_decode.sv */
// Decode stage: picks the target store, the linear address and the mirroring size.
module cbam_decode (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  cbam_pkg::t_cfg               i_cfg,
    input  logic                         i_req_type,
    input  logic                         i_io_space,
    input  logic [23:0]                  i_bus_address,
    input  logic [7:0]                   i_data_in,
    output logic                         o_vld,
    output logic [cbam_pkg::DVD_W-1:0]   o_dividend,
    output logic [cbam_pkg::REM_W-1:0]   o_divisor,
    output cbam_pkg::t_side              o_side
);

    logic [7:0]                  bank;
    logic [15:0]                 off;
    logic [6:0]                  b7;
    logic                        sram_on;
    cbam_pkg::t_target           kind;
    logic [cbam_pkg::DVD_W-1:0]  linear;
    logic [cbam_pkg::REM_W-1:0]  size;
    logic                        we;

    logic                        r_vld;
    logic [cbam_pkg::DVD_W-1:0]  r_dividend;
    logic [cbam_pkg::REM_W-1:0]  r_divisor;
    cbam_pkg::t_side             r_side;
    logic                        r_dirty;
    logic                        n_dirty;
    cbam_pkg::t_target           n_target;
    logic [cbam_pkg::DVD_W-1:0]  n_dividend;
    logic [cbam_pkg::REM_W-1:0]  n_divisor;

    assign bank    = i_bus_address[23:16];
    assign off     = i_bus_address[15:0];
    assign b7      = bank[6:0];
    assign sram_on = (i_cfg.sram_size != '0);

    always_comb begin
        kind   = cbam_pkg::TGT_NONE;
        linear = '0;
        size   = '0;
        case (i_cfg.map_mode)
            cbam_pkg::MAP_LO: begin
                if (!i_io_space) begin
                    if (sram_on && !off[15] && bank >= cbam_pkg::LO_SRAM_BANK_FIRST
                            && bank < cbam_pkg::LO_SRAM_BANK_END) begin
                        kind   = cbam_pkg::TGT_SRAM;
                        linear = {5'd0, bank[3:0], off[14:0]};
                        size   = cbam_pkg::REM_W'(i_cfg.sram_size);
                    end else begin
                        kind   = cbam_pkg::TGT_ROM;
                        linear = {2'd0, b7, off[14:0]};
                        size   = i_cfg.rom_size;
                    end
                end
            end
            cbam_pkg::MAP_HI: begin
                if (!i_io_space) begin
                    kind   = cbam_pkg::TGT_ROM;
                    linear = {2'd0, i_bus_address[21:0]};
                    size   = i_cfg.rom_size;
                end else if (sram_on && off >= cbam_pkg::HI_SRAM_OFF_FIRST
                        && off < cbam_pkg::HI_SRAM_OFF_END
                        && bank >= cbam_pkg::HI_SRAM_BANK_FIRST
                        && bank < cbam_pkg::HI_SRAM_BANK_END) begin
                    kind   = cbam_pkg::TGT_SRAM;
                    linear = {7'd0, bank[3:0], off[12:0]};
                    size   = cbam_pkg::REM_W'(i_cfg.sram_size);
                end
            end
            cbam_pkg::MAP_COPRO: begin
                if (i_io_space) begin
                    kind   = cbam_pkg::TGT_COPIO;
                    linear = {8'd0, off};
                    size   = cbam_pkg::PASS_DIVISOR;
                end else if (b7 < cbam_pkg::CP_ROM_LO_BANK_END && off[15]) begin
                    kind   = cbam_pkg::TGT_ROM;
                    linear = {1'b0, bank, off[14:0]};
                    size   = i_cfg.rom_size;
                end else if (b7 >= cbam_pkg::CP_ROM_LO_BANK_END
                        && b7 < cbam_pkg::CP_ROM_HI_BANK_END) begin
                    kind   = cbam_pkg::TGT_ROM;
                    linear = {bank, off};
                    size   = i_cfg.rom_size;
                end else if (bank == cbam_pkg::CP_EXTRAM_BANK0
                        || bank == cbam_pkg::CP_EXTRAM_BANK1) begin
                    kind   = cbam_pkg::TGT_EXTRAM;
                    linear = {7'd0, bank[0], off};
                    size   = cbam_pkg::REM_W'(i_cfg.extram_size);
                end else if (sram_on && (bank == cbam_pkg::CP_SRAM_BANK0
                        || bank == cbam_pkg::CP_SRAM_BANK1)) begin
                    kind   = cbam_pkg::TGT_SRAM;
                    linear = {7'd0, bank[0], off};
                    size   = cbam_pkg::REM_W'(i_cfg.sram_size);
                end
            end
            default: begin
                kind = cbam_pkg::TGT_NONE;
            end
        endcase
    end

    // A store of size zero is unreachable. A miss is sent through the divider
    // as zero modulo one, which yields the required zero offset.
    always_comb begin
        if (kind == cbam_pkg::TGT_NONE || size == '0) begin
            n_target   = cbam_pkg::TGT_NONE;
            n_dividend = '0;
            n_divisor  = cbam_pkg::REM_W'(1);
        end else begin
            n_target   = kind;
            n_dividend = linear;
            n_divisor  = size;
        end
        we      = i_req_type && (n_target == cbam_pkg::TGT_SRAM
                  || n_target == cbam_pkg::TGT_EXTRAM);
        n_dirty = r_dirty | (we && n_target == cbam_pkg::TGT_SRAM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_dirty <= 1'b0;
        end else begin
            r_vld <= i_start;
            if (i_start) begin
                r_dirty <= n_dirty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dividend        <= n_dividend;
        r_divisor         <= n_divisor;
        r_side.target       <= n_target;
        r_side.write_enable <= we;
        r_side.data         <= i_req_type ? i_data_in : 8'd0;
        r_side.dirty        <= n_dirty;
    end

    assign o_vld      = r_vld;
    assign o_dividend = r_dividend;
    assign o_divisor  = r_divisor;
    assign o_side     = r_side;

endmodule

/* sv/cbam_rem_pipe.sv */
// Pipelined restoring remainder unit that mirrors the linear address into its store.
module cbam_rem_pipe #(
    parameter int BITS_PER_STAGE = cbam_pkg::BITS_PER_STAGE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [cbam_pkg::DVD_W-1:0]   i_dividend,
    input  logic [cbam_pkg::REM_W-1:0]   i_divisor,
    input  cbam_pkg::t_side              i_side,
    output logic                         o_vld,
    output logic [cbam_pkg::REM_W-1:0]   o_rem,
    output cbam_pkg::t_side              o_side
);

    localparam int N_STAGES = (cbam_pkg::DVD_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int PAD_W    = N_STAGES * BITS_PER_STAGE;
    localparam int REM_W    = cbam_pkg::REM_W;

    logic                 r_vld  [1:N_STAGES];
    logic [REM_W-1:0]     r_rem  [1:N_STAGES];
    logic [PAD_W-1:0]     r_quo  [1:N_STAGES];
    logic [REM_W-1:0]     r_div  [1:N_STAGES];
    cbam_pkg::t_side      r_side [1:N_STAGES];

    for (genvar s = 0; s < N_STAGES; s++) begin : g_stage
        logic             in_vld;
        logic [REM_W-1:0] in_rem;
        logic [PAD_W-1:0] in_quo;
        logic [REM_W-1:0] in_div;
        cbam_pkg::t_side  in_side;
        logic [REM_W-1:0] rem_c;
        logic [PAD_W-1:0] quo_c;

        if (s == 0) begin : g_first
            assign in_vld  = i_vld;
            assign in_rem  = '0;
            assign in_quo  = PAD_W'(i_dividend);
            assign in_div  = i_divisor;
            assign in_side = i_side;
        end else begin : g_next
            assign in_vld  = r_vld[s];
            assign in_rem  = r_rem[s];
            assign in_quo  = r_quo[s];
            assign in_div  = r_div[s];
            assign in_side = r_side[s];
        end

        // Each step brings down one dividend bit and subtracts the divisor when it fits.
        always_comb begin
            logic [REM_W:0] trial;
            rem_c = in_rem;
            quo_c = in_quo;
            trial = '0;
            for (int k = 0; k < BITS_PER_STAGE; k++) begin
                trial = {rem_c, quo_c[PAD_W-1]};
                quo_c = quo_c << 1;
                if (trial >= {1'b0, in_div}) begin
                    rem_c = REM_W'(trial - {1'b0, in_div});
                end else begin
                    rem_c = trial[REM_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s+1]  <= rem_c;
            r_quo[s+1]  <= quo_c;
            r_div[s+1]  <= in_div;
            r_side[s+1] <= in_side;
        end
    end

    assign o_vld  = r_vld[N_STAGES];
    assign o_rem  = r_rem[N_STAGES];
    assign o_side = r_side[N_STAGES];

endmodule

/* sv/cartridge_bus_address_mapper.sv */
// Cartridge bus address mapper: one decode stage, then a pipelined mirroring remainder.
// A word taken with i_start is registered by the decode stage and then by each remainder
// stage, and is on the outputs with o_valid after the last of them.
// Throughput: one word per cycle; o_busy stays low, since every stage advances each cycle.
// The depth is set by the remainder unit, which retires P_BITS_PER_STAGE dividend bits a stage.
// Reset clears the valid bits, the dirty flag and the configuration registers to their defaults.
module cartridge_bus_address_mapper #(
    parameter int P_BITS_PER_STAGE = cbam_pkg::BITS_PER_STAGE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [24:0] i_cfg_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_req_type,
    input  logic        i_io_space,
    input  logic [23:0] i_bus_address,
    input  logic [7:0]  i_data_in,
    output logic        o_valid,
    output logic [2:0]  o_target,
    output logic [23:0] o_offset,
    output logic        o_write_enable,
    output logic [7:0]  o_data_out,
    output logic        o_save_dirty
);

    cbam_pkg::t_cfg                  r_cfg;
    logic                            dec_vld;
    logic [cbam_pkg::DVD_W-1:0]      dec_dividend;
    logic [cbam_pkg::REM_W-1:0]      dec_divisor;
    cbam_pkg::t_side                 dec_side;
    logic                            rem_vld;
    logic [cbam_pkg::REM_W-1:0]      rem_value;
    cbam_pkg::t_side                 rem_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_mode    <= cbam_pkg::RST_MAP_MODE;
            r_cfg.rom_size    <= cbam_pkg::RST_ROM_SIZE;
            r_cfg.sram_size   <= cbam_pkg::RST_SRAM_SIZE;
            r_cfg.extram_size <= cbam_pkg::RST_EXTRAM_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbam_pkg::CFG_MAP_MODE:    r_cfg.map_mode    <= i_cfg_data[1:0];
                cbam_pkg::CFG_ROM_SIZE:    r_cfg.rom_size    <= i_cfg_data;
                cbam_pkg::CFG_SRAM_SIZE:   r_cfg.sram_size   <= i_cfg_data[19:0];
                cbam_pkg::CFG_EXTRAM_SIZE: r_cfg.extram_size <= i_cfg_data[17:0];
                default: begin
                end
            endcase
        end
    end

    cbam_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_cfg         (r_cfg),
        .i_req_type    (i_req_type),
        .i_io_space    (i_io_space),
        .i_bus_address (i_bus_address),
        .i_data_in     (i_data_in),
        .o_vld         (dec_vld),
        .o_dividend    (dec_dividend),
        .o_divisor     (dec_divisor),
        .o_side        (dec_side)
    );

    cbam_rem_pipe #(
        .BITS_PER_STAGE (P_BITS_PER_STAGE)
    ) u_rem_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (dec_vld),
        .i_dividend (dec_dividend),
        .i_divisor  (dec_divisor),
        .i_side     (dec_side),
        .o_vld      (rem_vld),
        .o_rem      (rem_value),
        .o_side     (rem_side)
    );

    assign o_busy         = 1'b0;
    assign o_valid        = rem_vld;
    assign o_target       = rem_side.target;
    assign o_offset       = rem_value[23:0];
    assign o_write_enable = rem_side.write_enable;
    assign o_data_out     = rem_side.data;
    assign o_save_dirty   = rem_side.dirty;

endmodule

/* tb/tb_cartridge_bus_address_mapper.sv */
// Self-checking testbench for the cartridge bus address mapper.
`timescale 1ns / 1ps

module tb_cartridge_bus_address_mapper;

    localparam int          PIPE_LATENCY    = 13;
    localparam int          SETTLE_CYCLES   = PIPE_LATENCY + 4;
    localparam int          STALL_LIMIT     = 2000;
    localparam int          NUM_PHASES      = 10;
    localparam int          ITEMS_PER_PHASE = 48;
    localparam logic [1:0]  MAP_SPARE       = 2'd3;

    // Decode windows, kept apart from the package so that a wrong constant there shows up.
    localparam int unsigned LO_SRAM_FIRST = 'h70;
    localparam int unsigned LO_SRAM_END   = 'h7E;
    localparam int unsigned HI_SRAM_FIRST = 'h30;
    localparam int unsigned HI_SRAM_END   = 'h40;
    localparam int unsigned HI_OFF_FIRST  = 'h6000;
    localparam int unsigned HI_OFF_END    = 'h8000;

    typedef struct packed {
        cbam_pkg::t_target target;
        logic [23:0]       offset;
        logic              write_enable;
        logic [7:0]        data_out;
        logic              save_dirty;
    } t_access_result;

    typedef enum logic {
        ROW_ACCESS,
        ROW_CONFIG
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        cbam_pkg::t_cfg_index reg_index;
        logic [24:0]          reg_value;
        logic                 wr;
        logic                 io;
        logic [23:0]          addr;
        logic [7:0]           din;
        logic                 typed;
        cbam_pkg::t_target    want_target;
        logic [23:0]          want_offset;
        logic                 want_we;
        logic [7:0]           want_data;
        logic                 want_dirty;
    } t_row;

    localparam int NUM_ROWS = 34;

    // Directed rows; a typed row carries its result, every other row goes through the mapping.
    t_row directed_rows [NUM_ROWS] = '{
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 0, 24'h000000, 8'h00, 1,
          cbam_pkg::TGT_ROM, 24'h000000, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 1, 0, 24'hFFFFFF, 8'hFF, 1,
          cbam_pkg::TGT_ROM, 24'h0FFFFF, 0, 8'hFF, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 1, 24'h123456, 8'h3C, 1,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 1, 0, 24'h700000, 8'h5A, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_CONFIG, cbam_pkg::CFG_SRAM_SIZE, 524288, 0, 0, 0, 0, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 1, 0, 24'h700000, 8'hA5, 1,
          cbam_pkg::TGT_SRAM, 0, 1, 8'hA5, 1},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 0, 24'h7D7FFF, 8'h00, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 0, 24'h7E0000, 8'h00, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 0, 24'h708000, 8'h00, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_CONFIG, cbam_pkg::CFG_MAP_MODE, cbam_pkg::MAP_HI, 0, 0, 0, 0, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 0, 24'hFFFFFF, 8'h00, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 1, 1, 24'h306000, 8'hC3, 1,
          cbam_pkg::TGT_SRAM, 0, 1, 8'hC3, 1},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 1, 1, 24'h3F7FFF, 8'h81, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 1, 24'h405FFF, 8'h00, 1,
          cbam_pkg::TGT_NONE, 0, 0, 0, 1},
        '{ROW_CONFIG, cbam_pkg::CFG_ROM_SIZE, 16777216, 0, 0, 0, 0, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_CONFIG, cbam_pkg::CFG_MAP_MODE, cbam_pkg::MAP_COPRO, 0, 0, 0, 0, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 1, 1, 24'hABCDEF, 8'h7E, 1,
          cbam_pkg::TGT_COPIO, 24'h00CDEF, 0, 8'h7E, 1},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 0, 24'h008000, 8'h00, 1,
          cbam_pkg::TGT_ROM, 0, 0, 0, 1},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 0, 24'hDFFFFF, 8'h00, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 1, 0, 24'h71FFFF, 8'h11, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 1, 0, 24'h790000, 8'h22, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 0, 24'h7A0000, 8'h00, 1,
          cbam_pkg::TGT_NONE, 0, 0, 0, 1},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 0, 24'h000000, 8'h00, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_CONFIG, cbam_pkg::CFG_MAP_MODE, MAP_SPARE, 0, 0, 0, 0, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 1, 0, 24'h700000, 8'hFF, 1,
          cbam_pkg::TGT_NONE, 0, 0, 8'hFF, 1},
        '{ROW_CONFIG, cbam_pkg::CFG_MAP_MODE, cbam_pkg::MAP_COPRO, 0, 0, 0, 0, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_CONFIG, cbam_pkg::CFG_ROM_SIZE, 0, 0, 0, 0, 0, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_CONFIG, cbam_pkg::CFG_EXTRAM_SIZE, 0, 0, 0, 0, 0, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 0, 24'h408000, 8'h00, 1,
          cbam_pkg::TGT_NONE, 0, 0, 0, 1},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 1, 0, 24'h70ABCD, 8'h44, 1,
          cbam_pkg::TGT_NONE, 0, 0, 8'h44, 1},
        '{ROW_CONFIG, cbam_pkg::CFG_ROM_SIZE, 1, 0, 0, 0, 0, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_CONFIG, cbam_pkg::CFG_EXTRAM_SIZE, 1, 0, 0, 0, 0, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 1, 0, 24'h71ABCD, 8'h99, 1,
          cbam_pkg::TGT_EXTRAM, 0, 1, 8'h99, 1},
        '{ROW_ACCESS, cbam_pkg::CFG_MAP_MODE, 0, 0, 0, 24'h5FFFFF, 8'h00, 0,
          cbam_pkg::TGT_NONE, 0, 0, 0, 0}
    };

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [1:0]  i_cfg_index    = cbam_pkg::CFG_MAP_MODE;
    logic [24:0] i_cfg_data     = '0;
    logic        i_start        = 1'b0;
    logic        i_req_type     = 1'b0;
    logic        i_io_space     = 1'b0;
    logic [23:0] i_bus_address  = '0;
    logic [7:0]  i_data_in      = '0;
    logic        o_busy;
    logic        o_valid;
    logic [2:0]  o_target;
    logic [23:0] o_offset;
    logic        o_write_enable;
    logic [7:0]  o_data_out;
    logic        o_save_dirty;

    // Mapping state as the block should hold it.
    logic [1:0]  cfg_mode         = cbam_pkg::RST_MAP_MODE;
    logic [24:0] cfg_rom_bytes    = 25'd1048576;
    logic [19:0] cfg_sram_bytes   = 20'd0;
    logic [17:0] cfg_extram_bytes = 18'd131072;
    logic        sram_written     = 1'b0;

    t_access_result expected_words[$];
    int mismatches    = 0;
    int words_checked = 0;
    int accesses_sent = 0;
    int reg_writes    = 0;
    int stall_cycles  = 0;
    int target_tally [5] = '{0, 0, 0, 0, 0};

    cartridge_bus_address_mapper i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_req_type     (i_req_type),
        .i_io_space     (i_io_space),
        .i_bus_address  (i_bus_address),
        .i_data_in      (i_data_in),
        .o_valid        (o_valid),
        .o_target       (o_target),
        .o_offset       (o_offset),
        .o_write_enable (o_write_enable),
        .o_data_out     (o_data_out),
        .o_save_dirty   (o_save_dirty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Works out the result of one access and advances the dirty flag.
    function automatic t_access_result map_access(input logic wr, input logic io,
                                                  input logic [23:0] addr,
                                                  input logic [7:0] din);
        int unsigned       bank;
        int unsigned       boff;
        int unsigned       b7;
        int unsigned       linear;
        int unsigned       modulus;
        cbam_pkg::t_target kind;
        logic              hit;
        t_access_result    r;
        bank    = 32'(addr[23:16]);
        boff    = 32'(addr[15:0]);
        b7      = 32'(addr[22:16]);
        linear  = 0;
        modulus = 0;
        kind    = cbam_pkg::TGT_NONE;
        hit     = 1'b0;
        r       = '0;
        case (cfg_mode)
            cbam_pkg::MAP_LO: begin
                if (!io) begin
                    hit = 1'b1;
                    if (cfg_sram_bytes != 0 && boff < 'h8000 &&
                        bank >= LO_SRAM_FIRST && bank < LO_SRAM_END) begin
                        kind    = cbam_pkg::TGT_SRAM;
                        linear  = (bank - LO_SRAM_FIRST) * 'h8000 + boff;
                        modulus = 32'(cfg_sram_bytes);
                    end else begin
                        kind    = cbam_pkg::TGT_ROM;
                        linear  = b7 * 'h8000 + (boff & 'h7FFF);
                        modulus = 32'(cfg_rom_bytes);
                    end
                end
            end
            cbam_pkg::MAP_HI: begin
                if (!io) begin
                    hit     = 1'b1;
                    kind    = cbam_pkg::TGT_ROM;
                    linear  = 32'(addr[21:0]);
                    modulus = 32'(cfg_rom_bytes);
                end else if (cfg_sram_bytes != 0 && boff >= HI_OFF_FIRST && boff < HI_OFF_END &&
                             bank >= HI_SRAM_FIRST && bank < HI_SRAM_END) begin
                    hit     = 1'b1;
                    kind    = cbam_pkg::TGT_SRAM;
                    linear  = (bank - HI_SRAM_FIRST) * 'h2000 + (boff & 'h1FFF);
                    modulus = 32'(cfg_sram_bytes);
                end
            end
            cbam_pkg::MAP_COPRO: begin
                hit = 1'b1;
                if (io) begin
                    // Coprocessor I/O is never mirrored.
                    hit      = 1'b0;
                    r.target = cbam_pkg::TGT_COPIO;
                    r.offset = 24'(boff);
                end else if (b7 < 'h40 && boff >= 'h8000) begin
                    kind    = cbam_pkg::TGT_ROM;
                    linear  = bank * 'h8000 + (boff & 'h7FFF);
                    modulus = 32'(cfg_rom_bytes);
                end else if (b7 >= 'h40 && b7 < 'h60) begin
                    kind    = cbam_pkg::TGT_ROM;
                    linear  = bank * 'h10000 + boff;
                    modulus = 32'(cfg_rom_bytes);
                end else if (bank == 'h70 || bank == 'h71) begin
                    kind    = cbam_pkg::TGT_EXTRAM;
                    linear  = (bank & 1) * 'h10000 + boff;
                    modulus = 32'(cfg_extram_bytes);
                end else if (cfg_sram_bytes != 0 && (bank == 'h78 || bank == 'h79)) begin
                    kind    = cbam_pkg::TGT_SRAM;
                    linear  = (bank & 1) * 'h10000 + boff;
                    modulus = 32'(cfg_sram_bytes);
                end else begin
                    hit = 1'b0;
                end
            end
            default: ;
        endcase
        // A store of size zero swallows the access.
        if (hit && modulus != 0) begin
            r.target = kind;
            r.offset = 24'(linear % modulus);
        end
        r.write_enable = wr && (r.target == cbam_pkg::TGT_SRAM ||
                                r.target == cbam_pkg::TGT_EXTRAM);
        if (r.write_enable && r.target == cbam_pkg::TGT_SRAM) begin
            sram_written = 1'b1;
        end
        r.data_out   = wr ? din : 8'h00;
        r.save_dirty = sram_written;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Presents one access word and waits for the edge that takes it.
    task automatic issue_access(input logic wr, input logic io, input logic [23:0] addr,
                                input logic [7:0] din, input logic typed,
                                input t_access_result typed_word);
        t_access_result predicted;
        i_start       <= 1'b1;
        i_req_type    <= wr;
        i_io_space    <= io;
        i_bus_address <= addr;
        i_data_in     <= din;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        predicted = map_access(wr, io, addr, din);
        expected_words.push_back(typed ? typed_word : predicted);
        accesses_sent++;
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            i_start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stops issuing and lets every outstanding word come out before the next register write.
    task automatic drain_pipeline();
        i_start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input cbam_pkg::t_cfg_index idx, input logic [24:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            cbam_pkg::CFG_MAP_MODE:    cfg_mode         = value[1:0];
            cbam_pkg::CFG_ROM_SIZE:    cfg_rom_bytes    = value;
            cbam_pkg::CFG_SRAM_SIZE:   cfg_sram_bytes   = value[19:0];
            cbam_pkg::CFG_EXTRAM_SIZE: cfg_extram_bytes = value[17:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic [24:0] pick_size(input int log2top, input bit zero_ok);
        int unsigned top;
        top = 1 << log2top;
        case ($urandom_range(0, 5))
            0: return 25'(top);
            1: return zero_ok ? 25'd0 : 25'd1;
            2: return 25'(1 << $urandom_range(0, log2top));
            3: return 25'($urandom_range(1, top));
            4: return 25'($urandom_range(1, 4096));
            default: return 25'($urandom_range(top / 2, top));
        endcase
    endfunction

    // Addresses biased toward the save RAM, extra RAM and ROM windows and their edges.
    function automatic logic [23:0] random_address();
        logic [7:0]  bank;
        logic [15:0] boff;
        bank = 8'($urandom);
        boff = 16'($urandom);
        case ($urandom_range(0, 9))
            3: begin
                bank = 8'(LO_SRAM_FIRST + $urandom_range(0, 13));
                boff[15] = 1'b0;
            end
            4: begin
                bank = 8'(HI_SRAM_FIRST + $urandom_range(0, 15));
                bank[7] = 1'($urandom_range(0, 1));
                boff = 16'(HI_OFF_FIRST + $urandom_range(0, 'h1FFF));
            end
            5: begin
                case ($urandom_range(0, 3))
                    0: bank = 8'h70;
                    1: bank = 8'h71;
                    2: bank = 8'h78;
                    default: bank = 8'h79;
                endcase
            end
            6: begin
                bank = 8'($urandom_range('h40, 'h5F));
                bank[7] = 1'($urandom_range(0, 1));
            end
            7: begin
                bank = 8'($urandom_range(0, 'h3F));
                bank[7] = 1'($urandom_range(0, 1));
                boff[15] = 1'b1;
            end
            8: begin
                case ($urandom_range(0, 10))
                    0: bank = 8'h6F;
                    1: bank = 8'h7D;
                    2: bank = 8'h7E;
                    3: bank = 8'h2F;
                    4: bank = 8'h40;
                    5: bank = 8'h72;
                    6: bank = 8'h77;
                    7: bank = 8'h7A;
                    8: bank = 8'h5F;
                    9: bank = 8'h60;
                    default: bank = 8'h3F;
                endcase
                case ($urandom_range(0, 5))
                    0: boff = 16'h0000;
                    1: boff = 16'h5FFF;
                    2: boff = 16'h6000;
                    3: boff = 16'h7FFF;
                    4: boff = 16'h8000;
                    default: boff = 16'hFFFF;
                endcase
            end
            default: ;
        endcase
        return {bank, boff};
    endfunction

    // Every result word is taken at the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        t_access_result got;
        t_access_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            got = '{cbam_pkg::t_target'(o_target), o_offset, o_write_enable, o_data_out,
                    o_save_dirty};
            if (o_target <= 3'd4) target_tally[o_target]++;
            if (expected_words.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = expected_words.pop_front();
                if (got.target !== want.target)
                    report_mismatch($sformatf("word %0d target %0d, expected %0d",
                                              words_checked, got.target, want.target));
                if (got.offset !== want.offset)
                    report_mismatch($sformatf("word %0d offset %h, expected %h",
                                              words_checked, got.offset, want.offset));
                if (got.write_enable !== want.write_enable)
                    report_mismatch($sformatf("word %0d write enable %b, expected %b",
                                              words_checked, got.write_enable,
                                              want.write_enable));
                if (got.data_out !== want.data_out)
                    report_mismatch($sformatf("word %0d data %h, expected %h",
                                              words_checked, got.data_out, want.data_out));
                if (got.save_dirty !== want.save_dirty)
                    report_mismatch($sformatf("word %0d dirty %b, expected %b",
                                              words_checked, got.save_dirty, want.save_dirty));
            end
            words_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid === 1'b1 || i_cfg_we) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%t no progress for %0d cycles, %0d words outstanding",
                     $realtime, STALL_LIMIT, expected_words.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_row row;
        bit   no_gaps;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            row = directed_rows[i];
            if (row.kind == ROW_CONFIG) begin
                drain_pipeline();
                write_register(row.reg_index, row.reg_value);
            end else begin
                issue_access(row.wr, row.io, row.addr, row.din, row.typed,
                             '{row.want_target, row.want_offset, row.want_we,
                               row.want_data, row.want_dirty});
                idle_gap(next_gap());
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_pipeline();
            write_register(cbam_pkg::CFG_MAP_MODE, (p == 6) ? 25'(MAP_SPARE) : 25'(p % 3));
            write_register(cbam_pkg::CFG_ROM_SIZE, (p == 8) ? 25'd0 : pick_size(24, 1'b0));
            write_register(cbam_pkg::CFG_SRAM_SIZE, pick_size(19, 1'b1));
            write_register(cbam_pkg::CFG_EXTRAM_SIZE, (p == 5) ? 25'd0 : pick_size(17, 1'b0));
            no_gaps = (p % 3 == 1);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                issue_access(1'($urandom), 1'($urandom), random_address(), 8'($urandom),
                             1'b0, '0);
                idle_gap(no_gaps ? 0 : next_gap());
            end
        end

        drain_pipeline();
        $display("%0d accesses over %0d register writes, %0d result words checked",
                 accesses_sent, reg_writes, words_checked);
        $display("targets seen: none %0d, ROM %0d, save RAM %0d, extra RAM %0d, copro I/O %0d",
                 target_tally[0], target_tally[1], target_tally[2], target_tally[3],
                 target_tally[4]);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
